// ===== rtl/fpag_pkg.sv =====
// Shared types and constants for the fixed-point ALU with divide and gcd.
// Holds the opcode and status codes, default widths and the unit status bundle.
// No dependencies.
package fpag_pkg;

  // default word format: signed Q16.16
  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_GCD = 3'd5,
    OP_LIN = 3'd6,
    OP_BAD = 3'd7
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  // status of one serial arithmetic unit
  typedef struct packed {
    logic busy;  // iterating
    logic done;  // one-cycle pulse, results valid from here on
  } unit_stat_t;

endpackage

// ===== rtl/fpag_mul.sv =====
// Bit-serial shift-and-add multiplier for unsigned magnitudes.
// One multiplier bit per cycle; full double-width product.
// Depends on fpag_pkg.
module fpag_mul #(
  parameter int WORD_WIDTH = fpag_pkg::WORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [WORD_WIDTH-1:0]     mcand,
  input  logic [WORD_WIDTH-1:0]     mplier,
  output logic [2*WORD_WIDTH-1:0]   prod,
  output fpag_pkg::unit_stat_t      stat
);
  import fpag_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [2*W-1:0] acc_r;
  logic [W-1:0]   mcand_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W:0]     hi_sum;
  logic [2*W-1:0] acc_nxt;

  // add multiplicand into upper half when the current multiplier bit is set
  always_comb begin
    hi_sum  = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, mcand_r} : '0);
    acc_nxt = {hi_sum, acc_r[W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r  <= 1'b1;
        cnt_r   <= CW'(W);
        mcand_r <= mcand;
        acc_r   <= {{W{1'b0}}, mplier};
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/fpag_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Numerator is WORD_WIDTH+FRAC_BITS bits; quotient keeps the low word plus a sticky overflow.
// Depends on fpag_pkg.
module fpag_div #(
  parameter int WORD_WIDTH = fpag_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = fpag_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               go,
  input  logic [WORD_WIDTH+FRAC_BITS-1:0]    num,
  input  logic [WORD_WIDTH-1:0]              den,
  output logic [WORD_WIDTH-1:0]              quo,
  output logic                               quo_over,
  output logic [WORD_WIDTH-1:0]              rem,
  output fpag_pkg::unit_stat_t               stat
);
  import fpag_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int N  = WORD_WIDTH + FRAC_BITS;
  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  quo_r;
  logic          ovf_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [W:0]    sh;
  logic [W+1:0]  diff;
  logic          fits;
  logic [W-1:0]  rem_nxt;

  // shift in next numerator bit, trial subtract
  always_comb begin
    sh      = {rem_r, num_r[N-1]};
    diff    = {1'b0, sh} - {2'b00, den_r};
    fits    = !diff[W+1];
    rem_nxt = fits ? diff[W-1:0] : sh[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        quo_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        num_r <= {num_r[N-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[W-2:0], fits};
        // a set bit above the word means the quotient does not fit
        ovf_r <= ovf_r | quo_r[W-1];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo       = quo_r;
  assign quo_over  = ovf_r;
  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/fpag_gcd.sv =====
// Binary (Stein) gcd unit: one shift or subtract per cycle, then serial shift-back
// of the common power of two. Depends on fpag_pkg.
module fpag_gcd #(
  parameter int WORD_WIDTH = fpag_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [WORD_WIDTH-1:0] x_in,
  input  logic [WORD_WIDTH-1:0] y_in,
  output logic [WORD_WIDTH-1:0] gcd_out,
  output fpag_pkg::unit_stat_t  stat
);
  import fpag_pkg::*;

  localparam int W  = WORD_WIDTH;
  localparam int KW = $clog2(W + 1);

  typedef enum logic [1:0] {G_IDLE, G_RUN, G_SHIFT} gstate_t;

  gstate_t       state_r;
  logic [W-1:0]  x_r;
  logic [W-1:0]  y_r;
  logic [KW-1:0] k_r;
  logic          done_r;
  logic [W:0]    x_minus_y;
  logic [W:0]    y_minus_x;

  always_comb begin
    x_minus_y = {1'b0, x_r} - {1'b0, y_r};
    y_minus_x = {1'b0, y_r} - {1'b0, x_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (go) begin
            x_r     <= x_in;
            y_r     <= y_in;
            k_r     <= '0;
            state_r <= G_RUN;
          end
        end
        G_RUN: begin
          if (x_r == '0 || y_r == '0) begin
            // odd part found; x_r carries it into the shift-back phase
            x_r     <= x_r | y_r;
            state_r <= G_SHIFT;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (!x_minus_y[W]) begin
            x_r <= x_minus_y[W-1:0];
          end else begin
            y_r <= y_minus_x[W-1:0];
          end
        end
        G_SHIFT: begin
          if (k_r == '0) begin
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else begin
            x_r <= x_r << 1;
            k_r <= k_r - 1'b1;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign gcd_out   = x_r;
  assign stat.busy = (state_r != G_IDLE);
  assign stat.done = done_r;

endmodule

// ===== rtl/fixed_point_alu_with_gcd.sv =====
// Fixed-point ALU: add, subtract, multiply, divide, modulo, gcd and linear solve
// on signed Q(WORD_WIDTH-FRAC_BITS).(FRAC_BITS) words. Depends on fpag_pkg and the
// fpag_mul, fpag_div and fpag_gcd serial units.
//
// One item is in flight at a time; the input is ready again while the previous
// result still waits in the output register. Add, subtract, error cases and
// unknown opcodes are settled in the decode state and go straight to the done
// state. Multiply runs the serial multiplier (one bit a cycle). Divide, modulo
// and linear solve run the restoring divider (one quotient bit a cycle). Gcd
// runs binary gcd steps on the integer parts (one shift or subtract a cycle),
// then one left shift per common factor of two. A result moves from the done
// state into the output register once that register is free.
// Results that do not fit saturate with status 3; a zero divisor or unknown
// opcode returns -1.0 with status 1 or 2.
module fixed_point_alu_with_gcd #(
  parameter int WORD_WIDTH = fpag_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = fpag_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input channel
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((2*WORD_WIDTH+7)/8)*8-1:0]          in_tdata,  // operand_a, operand_b
  input  logic [fpag_pkg::OPCODE_W-1:0]              in_tuser,  // opcode
  // result channel
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((WORD_WIDTH+7)/8)*8-1:0]            out_tdata, // result_value
  output logic [fpag_pkg::STATUS_W-1:0]              out_tuser  // status
);
  import fpag_pkg::*;

  localparam int W          = WORD_WIDTH;
  localparam int F          = FRAC_BITS;
  localparam int OUT_DATA_W = ((WORD_WIDTH + 7) / 8) * 8;

  localparam logic [W-1:0] MIN_VAL   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAX_VAL   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINUS_ONE = (F >= W - 1) ? MIN_VAL : (W'(0) - (W'(1) << F));

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_BUSY, S_DONE} state_t;

  // sign-magnitude to word with saturation; bit W is the saturate flag
  function automatic logic [W:0] sat_pack(input logic neg, input logic over,
                                          input logic [W-1:0] mag);
    logic [W:0] r;
    if (neg) begin
      if (over || (mag[W-1] && (|mag[W-2:0]))) r = {1'b1, MIN_VAL};
      else                                     r = {1'b0, W'(0) - mag};
    end else begin
      if (over || mag[W-1]) r = {1'b1, MAX_VAL};
      else                  r = {1'b0, mag};
    end
    return r;
  endfunction

  state_t         state_r;
  opcode_t        op_r;
  logic [W-1:0]   a_r;
  logic [W-1:0]   b_r;
  logic           neg_r;
  logic [W-1:0]   res_r;
  status_t        st_r;
  logic           out_valid_r;
  logic [W-1:0]   out_data_r;
  status_t        out_st_r;

  logic           na;
  logic           nb;
  logic [W-1:0]   ma;
  logic [W-1:0]   mb;
  logic [W-1:0]   ia;
  logic [W-1:0]   ib;
  logic [W-1:0]   sum;
  logic           sum_ovf;

  logic           dec_imm;
  logic [W-1:0]   dec_val;
  status_t        dec_st;
  logic           dec_neg;

  logic           mul_go;
  logic           div_go;
  logic           gcd_go;
  logic [W+F-1:0] div_num;
  logic [W-1:0]   div_den;

  logic [2*W-1:0] mul_prod;
  logic [2*W-1:0] prod_sh;
  logic [W-1:0]   div_quo;
  logic           div_over;
  logic [W-1:0]   div_rem;
  logic [W-1:0]   gcd_val;
  unit_stat_t     mul_st;
  unit_stat_t     div_st;
  unit_stat_t     gcd_st;
  logic           unit_done;
  logic [W:0]     unit_res;
  logic           out_free;

  // operand signs, magnitudes and integer parts
  always_comb begin
    na  = a_r[W-1];
    nb  = b_r[W-1];
    ma  = na ? (W'(0) - a_r) : a_r;
    mb  = nb ? (W'(0) - b_r) : b_r;
    ia  = ma >> F;
    ib  = mb >> F;
    sum = (op_r == OP_ADD) ? (a_r + b_r) : (a_r - b_r);
    sum_ovf = ((op_r == OP_ADD) ? (na == nb) : (na != nb)) && (sum[W-1] != na);
  end

  // decode: settle immediate results or pick a serial unit
  always_comb begin
    dec_imm = 1'b1;
    dec_val = MINUS_ONE;
    dec_st  = ST_DIVZERO;
    dec_neg = 1'b0;
    mul_go  = 1'b0;
    div_go  = 1'b0;
    gcd_go  = 1'b0;
    div_num = (W+F)'(ma) << F;
    div_den = mb;
    case (op_r)
      OP_ADD, OP_SUB: begin
        dec_val = sum_ovf ? (na ? MIN_VAL : MAX_VAL) : sum;
        dec_st  = sum_ovf ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        dec_imm = 1'b0;
        dec_neg = na ^ nb;
        mul_go  = (state_r == S_DECODE);
      end
      OP_DIV: begin
        dec_imm = (mb == '0);
        dec_neg = na ^ nb;
        div_go  = (state_r == S_DECODE) && (mb != '0);
      end
      OP_MOD: begin
        dec_imm = (ib == '0);
        dec_neg = na;
        div_num = (W+F)'(ia);
        div_den = ib;
        div_go  = (state_r == S_DECODE) && (ib != '0);
      end
      OP_GCD: begin
        dec_imm = 1'b0;
        gcd_go  = (state_r == S_DECODE);
      end
      OP_LIN: begin
        dec_imm = (ma == '0);
        dec_neg = (na == nb);
        div_num = (W+F)'(mb) << F;
        div_den = ma;
        div_go  = (state_r == S_DECODE) && (ma != '0);
      end
      default: begin
        dec_st = ST_UNKNOWN;
      end
    endcase
  end

  fpag_mul #(.WORD_WIDTH(W)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (mul_go),
    .mcand  (ma),
    .mplier (mb),
    .prod   (mul_prod),
    .stat   (mul_st)
  );

  fpag_div #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .num      (div_num),
    .den      (div_den),
    .quo      (div_quo),
    .quo_over (div_over),
    .rem      (div_rem),
    .stat     (div_st)
  );

  fpag_gcd #(.WORD_WIDTH(W)) u_gcd (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (gcd_go),
    .x_in    (ia),
    .y_in    (ib),
    .gcd_out (gcd_val),
    .stat    (gcd_st)
  );

  // format the finished unit's result
  always_comb begin
    unit_done = mul_st.done | div_st.done | gcd_st.done;
    prod_sh   = mul_prod >> F;
    case (op_r)
      OP_MUL:  unit_res = sat_pack(neg_r, |prod_sh[2*W-1:W], prod_sh[W-1:0]);
      OP_MOD:  unit_res = sat_pack(neg_r, 1'b0, div_rem << F);
      OP_GCD:  unit_res = sat_pack(1'b0, 1'b0, gcd_val << F);
      default: unit_res = sat_pack(neg_r, div_over, div_quo);
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  // control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: load a finished result, or drop after a transfer
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready)               out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= opcode_t'(in_tuser);
            a_r     <= in_tdata[W-1:0];
            b_r     <= in_tdata[2*W-1:W];
            state_r <= S_DECODE;
          end
        end
        S_DECODE: begin
          neg_r <= dec_neg;
          if (dec_imm) begin
            res_r   <= dec_val;
            st_r    <= dec_st;
            state_r <= S_DONE;
          end else begin
            state_r <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (unit_done) begin
            res_r   <= unit_res[W-1:0];
            st_r    <= unit_res[W] ? ST_SAT : ST_OK;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_st_r    <= st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_st_r;

  // error results always carry -1.0
  a_err_minus_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_DIVZERO || out_tuser == ST_UNKNOWN)
      |-> out_data_r == MINUS_ONE)
    else $error("error status without -1.0 result");

  // at most one serial unit runs
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_st.busy, div_st.busy, gcd_st.busy}))
    else $error("more than one serial unit busy");

  // units only finish while the controller waits for them
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> state_r == S_BUSY)
    else $error("unit finished outside busy state");

  // a new item is never taken while a unit still runs
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !(mul_st.busy || div_st.busy || gcd_st.busy))
    else $error("input taken while a unit is busy");

endmodule
